/* rtl/v3au_pkg.sv */
// Package for the vector3 arithmetic unit.
// Holds word sizes, operation codes, beat structs, saturation and magnitude helpers.
// No dependencies.
package v3au_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_MUL   = 4'd2,
    MODE_DIV   = 4'd3,
    MODE_SADD  = 4'd4,
    MODE_SSUB  = 4'd5,
    MODE_SMUL  = 4'd6,
    MODE_SDIV  = 4'd7,
    MODE_LEN   = 4'd8,
    MODE_NORM  = 4'd9,
    MODE_DOT   = 4'd10,
    MODE_CROSS = 4'd11
  } mode_t;

  typedef struct packed {
    logic [3:0]                  mode;
    logic signed [WORD_BITS-1:0] ax;
    logic signed [WORD_BITS-1:0] ay;
    logic signed [WORD_BITS-1:0] az;
    logic signed [WORD_BITS-1:0] bx;
    logic signed [WORD_BITS-1:0] by;
    logic signed [WORD_BITS-1:0] bz;
    logic signed [WORD_BITS-1:0] scalar_in;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_x;
    logic signed [WORD_BITS-1:0] res_y;
    logic signed [WORD_BITS-1:0] res_z;
    logic signed [WORD_BITS-1:0] res_scalar;
    logic                        error;
  } out_t;

  typedef struct packed {
    logic [2:0][WORD_BITS-1:0] val;
    logic [WORD_BITS-1:0]      dot;
  } rec_t;

  typedef struct packed {
    logic [2:0][WORD_BITS-1:0] val;
    logic [WORD_BITS-1:0]      scalar;
    logic                      err;
    logic                      use_div;
  } fin_t;

  localparam logic [WORD_BITS-1:0] MAXPOS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MINNEG = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic logic [WORD_BITS-1:0] sat_w(input logic [2*WORD_BITS:0] v);
    logic [WORD_BITS+1:0] upper;
    upper = v[2*WORD_BITS:WORD_BITS-1];
    if ((&upper) || !(|upper)) return v[WORD_BITS-1:0];
    return v[2*WORD_BITS] ? MINNEG : MAXPOS;
  endfunction

  function automatic logic [WORD_BITS-1:0] mag_w(input logic [WORD_BITS-1:0] x);
    return x[WORD_BITS-1] ? (~x) + 1'b1 : x;
  endfunction

endpackage

/* rtl/vector3_arithmetic_unit_core.sv */
// Vector3 arithmetic unit top level: three lanes, merge, square root, dividers.
// Depends on v3au_pkg, v3au_lane, v3au_sqrt, v3au_div, v3au_delay.
//
// One command beat may be taken every cycle; busy stays low. Each beat yields
// exactly one result beat, flagged by done, in command order. The result path
// runs through the pipelined square root (one stage per result bit) followed
// by the restoring dividers (one stage per quotient bit); every mode travels
// the same pipeline. The receiver must take done beats as they come.
module vector3_arithmetic_unit_core #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  v3au_pkg::in_t  cmd,
  output logic           done,
  output v3au_pkg::out_t result
);
  import v3au_pkg::*;
  localparam int W   = WORD_BITS;
  localparam int Q   = WORD_BITS + FRAC_BITS;
  localparam int LAT = W + Q + 6;

  logic [LAT-1:0] vld;
  in_t            cmd_r, cmd_d;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd;
  end

  logic signed [W-1:0]   av [3];
  logic signed [W-1:0]   bv [3];
  logic [W-1:0]          lval [3];
  logic signed [2*W-1:0] lprod [3];

  assign av[0] = cmd_r.ax;
  assign av[1] = cmd_r.ay;
  assign av[2] = cmd_r.az;
  assign bv[0] = cmd_r.bx;
  assign bv[1] = cmd_r.by;
  assign bv[2] = cmd_r.bz;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3au_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .mode  (cmd_r.mode),
      .a     (av[i]),
      .b     (bv[i]),
      .s     (cmd_r.scalar_in),
      .xa    (av[(i+1)%3]),
      .xb    (bv[(i+2)%3]),
      .xc    (av[(i+2)%3]),
      .xd    (bv[(i+1)%3]),
      .value (lval[i]),
      .prod  (lprod[i])
    );
  end

  logic signed [2*W:0] sum_r;
  logic [2:0][W-1:0]   val_r;
  rec_t                rec, rec_d;

  always_ff @(posedge clk) begin
    sum_r <= $signed({lprod[0][2*W-1], lprod[0]}) + $signed({lprod[1][2*W-1], lprod[1]})
           + $signed({lprod[2][2*W-1], lprod[2]});
    for (int i = 0; i < 3; i++) begin
      val_r[i] <= lval[i];
    end
  end

  assign rec.val = val_r;
  assign rec.dot = sat_w(sum_r >>> FRAC_BITS);

  logic [W-1:0] len;

  v3au_sqrt u_sqrt (
    .clk  (clk),
    .x    (sum_r[2*W-1:0]),
    .root (len)
  );

  v3au_delay #(.WIDTH($bits(rec_t)), .DEPTH(W)) u_rec_dly (
    .clk (clk),
    .d   (rec),
    .q   (rec_d)
  );

  v3au_delay #(.WIDTH($bits(in_t)), .DEPTH(W + 3)) u_cmd_dly (
    .clk (clk),
    .d   (cmd_r),
    .q   (cmd_d)
  );

  logic [W-1:0] da [3];
  logic [W-1:0] db [3];
  logic [W-1:0] den [3];
  logic         dneg [3];
  logic [W-1:0] quo [3];
  fin_t         fin, fin_d;

  assign da[0] = cmd_d.ax;
  assign da[1] = cmd_d.ay;
  assign da[2] = cmd_d.az;
  assign db[0] = cmd_d.bx;
  assign db[1] = cmd_d.by;
  assign db[2] = cmd_d.bz;

  for (genvar i = 0; i < 3; i++) begin : g_div
    always_comb begin
      if (cmd_d.mode == MODE_NORM) begin
        den[i]  = len;
        dneg[i] = da[i][W-1];
      end else if (cmd_d.mode == MODE_SDIV) begin
        den[i]  = mag_w(cmd_d.scalar_in);
        dneg[i] = da[i][W-1] ^ cmd_d.scalar_in[W-1];
      end else begin
        den[i]  = mag_w(db[i]);
        dneg[i] = da[i][W-1] ^ db[i][W-1];
      end
    end

    v3au_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .num (da[i]),
      .den (den[i]),
      .neg (dneg[i]),
      .quo (quo[i])
    );
  end

  always_comb begin
    fin.val     = rec_d.val;
    fin.scalar  = '0;
    fin.err     = 1'b0;
    fin.use_div = 1'b0;
    unique case (cmd_d.mode)
      MODE_DIV: begin
        fin.err     = (db[0] == '0) || (db[1] == '0) || (db[2] == '0);
        fin.use_div = !fin.err;
      end
      MODE_SDIV: begin
        fin.err     = cmd_d.scalar_in == '0;
        fin.use_div = !fin.err;
      end
      MODE_LEN:  fin.scalar = len[W-1] ? MAXPOS : len;
      MODE_NORM: begin
        fin.err     = len == '0;
        fin.use_div = !fin.err;
      end
      MODE_DOT:  fin.scalar = rec_d.dot;
      default: ;
    endcase
  end

  v3au_delay #(.WIDTH($bits(fin_t)), .DEPTH(Q + 1)) u_fin_dly (
    .clk (clk),
    .d   (fin),
    .q   (fin_d)
  );

  always_ff @(posedge clk) begin
    result.res_x      <= $signed(fin_d.use_div ? quo[0] : fin_d.val[0]);
    result.res_y      <= $signed(fin_d.use_div ? quo[1] : fin_d.val[1]);
    result.res_z      <= $signed(fin_d.use_div ? quo[2] : fin_d.val[2]);
    result.res_scalar <= $signed(fin_d.scalar);
    result.error      <= fin_d.err;
  end

  assign done = vld[LAT-1];

`ifndef NO_ASSERTIONS
  a_done_follows_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without matching command beat");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    done && result.error |-> result.res_x == '0 && result.res_y == '0 &&
                             result.res_z == '0 && result.res_scalar == '0)
    else $error("error beat carries nonzero values");

  a_error_mode: assert property (@(posedge clk) disable iff (rst)
    done && result.error |-> ($past(cmd.mode, LAT) == MODE_DIV ||
                              $past(cmd.mode, LAT) == MODE_SDIV ||
                              $past(cmd.mode, LAT) == MODE_NORM))
    else $error("error flag in a mode without division");
`endif
endmodule

/* rtl/v3au_delay.sv */
// Fixed-depth register delay line for beat side data.
// Depends on nothing but its parameters.
module v3au_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int k = 1; k < DEPTH; k++) begin
      sr[k] <= sr[k-1];
    end
  end

  assign q = sr[DEPTH-1];
endmodule

/* rtl/v3au_lane.sv */
// One component lane: add/sub, product and cross term, two register stages.
// Depends on v3au_pkg.
module v3au_lane #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic [3:0]                             mode,
  input  logic signed [v3au_pkg::WORD_BITS-1:0]  a,
  input  logic signed [v3au_pkg::WORD_BITS-1:0]  b,
  input  logic signed [v3au_pkg::WORD_BITS-1:0]  s,
  input  logic signed [v3au_pkg::WORD_BITS-1:0]  xa,
  input  logic signed [v3au_pkg::WORD_BITS-1:0]  xb,
  input  logic signed [v3au_pkg::WORD_BITS-1:0]  xc,
  input  logic signed [v3au_pkg::WORD_BITS-1:0]  xd,
  output logic [v3au_pkg::WORD_BITS-1:0]         value,
  output logic signed [2*v3au_pkg::WORD_BITS-1:0] prod
);
  import v3au_pkg::*;
  localparam int W = WORD_BITS;

  logic [3:0]            mode_r;
  logic signed [2*W-1:0] p_main, p_x1, p_x2;
  logic signed [W:0]     sum1;
  logic signed [W-1:0]   op, addend;
  logic                  do_sub;
  logic signed [2*W:0]   diff, pm_sh, df_sh;

  always_comb begin
    op     = b;
    addend = s;
    do_sub = 1'b0;
    unique case (mode)
      MODE_SMUL:           op = s;
      MODE_LEN, MODE_NORM: op = a;
      MODE_ADD:            addend = b;
      MODE_SUB: begin
        addend = b;
        do_sub = 1'b1;
      end
      MODE_SSUB:           do_sub = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r <= mode;
    p_main <= a * op;
    p_x1   <= xa * xb;
    p_x2   <= xc * xd;
    sum1   <= do_sub ? $signed({a[W-1], a}) - $signed({addend[W-1], addend})
                     : $signed({a[W-1], a}) + $signed({addend[W-1], addend});
  end

  assign diff  = $signed({p_x1[2*W-1], p_x1}) - $signed({p_x2[2*W-1], p_x2});
  assign pm_sh = $signed({p_main[2*W-1], p_main}) >>> FRAC_BITS;
  assign df_sh = diff >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    prod <= p_main;
    unique case (mode_r)
      MODE_ADD, MODE_SUB, MODE_SADD, MODE_SSUB: value <= sat_w({{W{sum1[W]}}, sum1});
      MODE_MUL, MODE_SMUL:                      value <= sat_w(pm_sh);
      MODE_CROSS:                               value <= sat_w(df_sh);
      default:                                  value <= '0;
    endcase
  end
endmodule

/* rtl/v3au_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage.
// Depends on v3au_pkg.
module v3au_sqrt (
  input  logic                               clk,
  input  logic [2*v3au_pkg::WORD_BITS-1:0]   x,
  output logic [v3au_pkg::WORD_BITS-1:0]     root
);
  import v3au_pkg::*;
  localparam int W = WORD_BITS;

  logic [W+1:0]   rem [W];
  logic [W-1:0]   rt  [W];
  logic [2*W-1:0] xs  [W];

  for (genvar j = 0; j < W; j++) begin : g_stage
    logic [W+1:0]   rem_i;
    logic [W-1:0]   rt_i;
    logic [2*W-1:0] x_i;
    logic [W+3:0]   r2, t, d;
    if (j == 0) begin : g_first
      assign rem_i = '0;
      assign rt_i  = '0;
      assign x_i   = x;
    end else begin : g_next
      assign rem_i = rem[j-1];
      assign rt_i  = rt[j-1];
      assign x_i   = xs[j-1];
    end
    assign r2 = {rem_i, x_i[2*W-1 -: 2]};
    assign t  = {2'b00, rt_i, 2'b01};
    assign d  = r2 - t;
    always_ff @(posedge clk) begin
      xs[j] <= x_i << 2;
      if (r2 >= t) begin
        rem[j] <= d[W+1:0];
        rt[j]  <= {rt_i[W-2:0], 1'b1};
      end else begin
        rem[j] <= r2[W+1:0];
        rt[j]  <= {rt_i[W-2:0], 1'b0};
      end
    end
  end

  assign root = rt[W-1];
endmodule

/* rtl/v3au_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturated Q result.
// Depends on v3au_pkg.
module v3au_div #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic [v3au_pkg::WORD_BITS-1:0] num,
  input  logic [v3au_pkg::WORD_BITS-1:0] den,
  input  logic                           neg,
  output logic [v3au_pkg::WORD_BITS-1:0] quo
);
  import v3au_pkg::*;
  localparam int W = WORD_BITS;
  localparam int Q = WORD_BITS + FRAC_BITS;

  logic [W-1:0] rem [Q];
  logic [Q-1:0] nq  [Q];
  logic [W-1:0] dv  [Q];
  logic         ng  [Q];

  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [W-1:0] rem_i, dv_i;
    logic [Q-1:0] nq_i;
    logic         ng_i, ge;
    logic [W:0]   r2, d;
    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign nq_i  = {mag_w(num), {FRAC_BITS{1'b0}}};
      assign dv_i  = den;
      assign ng_i  = neg;
    end else begin : g_next
      assign rem_i = rem[k-1];
      assign nq_i  = nq[k-1];
      assign dv_i  = dv[k-1];
      assign ng_i  = ng[k-1];
    end
    assign r2 = {rem_i, nq_i[Q-1]};
    assign ge = r2 >= {1'b0, dv_i};
    assign d  = r2 - {1'b0, dv_i};
    always_ff @(posedge clk) begin
      rem[k] <= ge ? d[W-1:0] : r2[W-1:0];
      nq[k]  <= {nq_i[Q-2:0], ge};
      dv[k]  <= dv_i;
      ng[k]  <= ng_i;
    end
  end

  logic [Q:0] qs;
  assign qs = ng[Q-1] ? -{1'b0, nq[Q-1]} : {1'b0, nq[Q-1]};

  always_ff @(posedge clk) begin
    quo <= sat_w({{(2*W-Q){qs[Q]}}, qs});
  end
endmodule
